@@ rtl/hpw_pkg.sv @@
// Package for the hand pose to world transform block.
// Holds shared constants, controller states, command/status structs and the step table.
package hpw_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = 5;
  localparam int MEM_DEPTH  = 23;
  localparam int HEAD_BASE  = 19;
  localparam int LAST_INDEX = 18;
  localparam int N_STEPS    = 25;
  localparam int SUM_W      = 35;
  localparam int RAD_W      = 48;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int PROD_W     = 64;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W      = TERM_W + 4;
  localparam int REM_W      = SQRT_STEPS + 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RLOAD,
    S_RSTEP,
    S_MRD,
    S_MMUL,
    S_MACC
  } state_t;

  typedef struct packed {
    logic       root_load;
    logic       root_step;
    logic       root_store;
    logic [1:0] comp;
    logic       mul_rd;
    logic       mul_mul;
    logic       mul_acc;
    logic [4:0] step;
    logic       set_valid;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } status_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             neg;
    logic             first;
    logic             last;
    logic [2:0]       dest;
  } op_t;

  // operand codes
  localparam logic [IDX_W-1:0] LPX = 5'd12;
  localparam logic [IDX_W-1:0] BX  = 5'd15;
  localparam logic [IDX_W-1:0] BY  = 5'd16;
  localparam logic [IDX_W-1:0] BZ  = 5'd17;
  localparam logic [IDX_W-1:0] BW  = 5'd18;
  localparam logic [IDX_W-1:0] HW  = 5'd19;
  localparam logic [IDX_W-1:0] HX  = 5'd20;
  localparam logic [IDX_W-1:0] HY  = 5'd21;
  localparam logic [IDX_W-1:0] HZ  = 5'd22;

  function automatic op_t mk(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, logic neg,
                             logic first, logic last, logic [2:0] dest);
    op_t o;
    o.a = a; o.b = b; o.neg = neg; o.first = first; o.last = last; o.dest = dest;
    return o;
  endfunction

  function automatic op_t step_op(logic [4:0] s);
    op_t o;
    unique case (s)
      5'd0:  o = mk(5'd0,  LPX,        1'b0, 1'b1, 1'b0, 3'd0);
      5'd1:  o = mk(5'd1,  LPX + 5'd1, 1'b0, 1'b0, 1'b0, 3'd0);
      5'd2:  o = mk(5'd2,  LPX + 5'd2, 1'b0, 1'b0, 1'b1, 3'd0);
      5'd3:  o = mk(5'd4,  LPX,        1'b0, 1'b1, 1'b0, 3'd1);
      5'd4:  o = mk(5'd5,  LPX + 5'd1, 1'b0, 1'b0, 1'b0, 3'd1);
      5'd5:  o = mk(5'd6,  LPX + 5'd2, 1'b0, 1'b0, 1'b1, 3'd1);
      5'd6:  o = mk(5'd8,  LPX,        1'b0, 1'b1, 1'b0, 3'd2);
      5'd7:  o = mk(5'd9,  LPX + 5'd1, 1'b0, 1'b0, 1'b0, 3'd2);
      5'd8:  o = mk(5'd10, LPX + 5'd2, 1'b0, 1'b0, 1'b1, 3'd2);
      5'd9:  o = mk(HW, BW, 1'b0, 1'b1, 1'b0, 3'd3);
      5'd10: o = mk(HX, BX, 1'b1, 1'b0, 1'b0, 3'd3);
      5'd11: o = mk(HY, BY, 1'b1, 1'b0, 1'b0, 3'd3);
      5'd12: o = mk(HZ, BZ, 1'b1, 1'b0, 1'b1, 3'd3);
      5'd13: o = mk(HW, BX, 1'b0, 1'b1, 1'b0, 3'd4);
      5'd14: o = mk(HX, BW, 1'b0, 1'b0, 1'b0, 3'd4);
      5'd15: o = mk(HY, BZ, 1'b0, 1'b0, 1'b0, 3'd4);
      5'd16: o = mk(HZ, BY, 1'b1, 1'b0, 1'b1, 3'd4);
      5'd17: o = mk(HW, BY, 1'b0, 1'b1, 1'b0, 3'd5);
      5'd18: o = mk(HX, BZ, 1'b1, 1'b0, 1'b0, 3'd5);
      5'd19: o = mk(HY, BW, 1'b0, 1'b0, 1'b0, 3'd5);
      5'd20: o = mk(HZ, BX, 1'b0, 1'b0, 1'b1, 3'd5);
      5'd21: o = mk(HW, BZ, 1'b0, 1'b1, 1'b0, 3'd6);
      5'd22: o = mk(HX, BY, 1'b0, 1'b0, 1'b0, 3'd6);
      5'd23: o = mk(HY, BX, 1'b1, 1'b0, 1'b0, 3'd6);
      5'd24: o = mk(HZ, BW, 1'b0, 1'b0, 1'b1, 3'd6);
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

@@ rtl/hpw_if.sv @@
// Request and result channel interfaces for the hand pose to world transform block.
// Depends on hpw_pkg for field widths.
interface hpw_in_if;
  logic                        valid;
  logic                        ready;
  logic [hpw_pkg::IDX_W-1:0]   word_index;
  logic signed [31:0]          word_value;
  modport source (output valid, output word_index, output word_value, input ready);
  modport sink (input valid, input word_index, input word_value, output ready);
endinterface

interface hpw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic signed [31:0] rot_w;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  modport source (output valid, output world_x, output world_y, output world_z,
                  output rot_w, output rot_x, output rot_y, output rot_z, input ready);
  modport sink (input valid, input world_x, input world_y, input world_z,
                input rot_w, input rot_x, input rot_y, input rot_z, output ready);
endinterface

@@ rtl/hpw_ctrl.sv @@
// Controller state machine for the hand pose to world transform block.
// Depends on hpw_pkg; drives datapath commands and the request ready.
module hpw_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic [hpw_pkg::IDX_W-1:0]   req_index,
  output logic                        req_ready,
  input  hpw_pkg::status_t            status,
  output hpw_pkg::cmd_t               cmd
);

  hpw_pkg::state_t state, state_next;
  logic [1:0] comp, comp_next;
  logic [4:0] iter, iter_next;
  logic [4:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpw_pkg::S_IDLE;
      comp  <= '0;
      iter  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      comp  <= comp_next;
      iter  <= iter_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    comp_next  = comp;
    iter_next  = iter;
    step_next  = step;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.comp   = comp;
    cmd.step   = step;
    unique case (state)
      hpw_pkg::S_IDLE: begin
        req_ready = !status.busy;
        if (req_valid && !status.busy &&
            req_index == 5'(hpw_pkg::LAST_INDEX)) begin
          comp_next  = '0;
          state_next = hpw_pkg::S_RLOAD;
        end
      end
      hpw_pkg::S_RLOAD: begin
        cmd.root_load = 1'b1;
        iter_next     = '0;
        state_next    = hpw_pkg::S_RSTEP;
      end
      hpw_pkg::S_RSTEP: begin
        cmd.root_step = 1'b1;
        iter_next     = iter + 5'd1;
        if (iter == 5'(hpw_pkg::SQRT_STEPS - 1)) begin
          cmd.root_store = 1'b1;
          comp_next      = comp + 2'd1;
          if (comp == 2'd3) begin
            step_next  = '0;
            state_next = hpw_pkg::S_MRD;
          end else begin
            state_next = hpw_pkg::S_RLOAD;
          end
        end
      end
      hpw_pkg::S_MRD: begin
        cmd.mul_rd = 1'b1;
        state_next = hpw_pkg::S_MMUL;
      end
      hpw_pkg::S_MMUL: begin
        cmd.mul_mul = 1'b1;
        state_next  = hpw_pkg::S_MACC;
      end
      hpw_pkg::S_MACC: begin
        cmd.mul_acc = 1'b1;
        step_next   = step + 5'd1;
        if (step == 5'(hpw_pkg::N_STEPS - 1)) begin
          cmd.set_valid = 1'b1;
          state_next    = hpw_pkg::S_IDLE;
        end else begin
          state_next = hpw_pkg::S_MRD;
        end
      end
      default: state_next = hpw_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/hpw_dp.sv @@
// Datapath for the hand pose to world transform block: word store, root unit,
// shared multiplier with accumulator, result registers. Depends on hpw_pkg.
module hpw_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [hpw_pkg::IDX_W-1:0]   load_index,
  input  logic signed [31:0]          load_value,
  input  hpw_pkg::cmd_t               cmd,
  output hpw_pkg::status_t            status,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [31:0]          res [7]
);

  localparam int ACC_W = hpw_pkg::ACC_W;

  logic signed [31:0] mem [hpw_pkg::MEM_DEPTH];
  logic signed [31:0] mat [12];
  logic signed [31:0] rda, rdb;
  logic signed [hpw_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic [hpw_pkg::RAD_W-1:0] rad;
  logic [hpw_pkg::REM_W-1:0] rem;
  logic [hpw_pkg::SQRT_STEPS-1:0] root;
  logic root_neg;

  logic                        wr_en;
  logic [hpw_pkg::IDX_W-1:0]   wr_addr;
  logic signed [31:0]          wr_data;
  logic                        word_ok;

  logic signed [hpw_pkg::SUM_W-1:0] sum;
  logic signed [32:0]              diff;
  logic [hpw_pkg::RAD_W-1:0]       rad_init;

  logic [hpw_pkg::REM_W-1:0]        rem2, trial, rem_next;
  logic [hpw_pkg::SQRT_STEPS-1:0]   root_next;
  logic signed [31:0]               head;

  hpw_pkg::op_t op;
  logic signed [hpw_pkg::TERM_W-1:0] term;
  logic signed [ACC_W-1:0] base, acc_next, init;
  logic signed [31:0] sat_val;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ACC_W'({1'b0, {(hpw_pkg::WORD_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);
  localparam logic signed [hpw_pkg::SUM_W-1:0] ONE =
    hpw_pkg::SUM_W'(1) <<< hpw_pkg::FRAC_BITS;

  assign word_ok = load && (load_index <= 5'(hpw_pkg::LAST_INDEX));

  // root radicand and sign for the current component
  always_comb begin
    sum  = ONE;
    diff = '0;
    unique case (cmd.comp)
      2'd0: sum = ONE + hpw_pkg::SUM_W'(mat[0]) + hpw_pkg::SUM_W'(mat[5])
                + hpw_pkg::SUM_W'(mat[10]);
      2'd1: begin
        sum  = ONE + hpw_pkg::SUM_W'(mat[0]) - hpw_pkg::SUM_W'(mat[5])
             - hpw_pkg::SUM_W'(mat[10]);
        diff = 33'(mat[9]) - 33'(mat[6]);
      end
      2'd2: begin
        sum  = ONE - hpw_pkg::SUM_W'(mat[0]) + hpw_pkg::SUM_W'(mat[5])
             - hpw_pkg::SUM_W'(mat[10]);
        diff = 33'(mat[2]) - 33'(mat[8]);
      end
      default: begin
        sum  = ONE - hpw_pkg::SUM_W'(mat[0]) - hpw_pkg::SUM_W'(mat[5])
             + hpw_pkg::SUM_W'(mat[10]);
        diff = 33'(mat[4]) - 33'(mat[1]);
      end
    endcase
    if (sum[hpw_pkg::SUM_W-1])
      rad_init = '0;
    else
      rad_init = hpw_pkg::RAD_W'({sum[32:0], {(hpw_pkg::FRAC_BITS-2){1'b0}}});
  end

  // one result bit per cycle
  always_comb begin
    rem2  = {rem[hpw_pkg::REM_W-3:0], rad[hpw_pkg::RAD_W-1 -: 2]};
    trial = hpw_pkg::REM_W'({root, 2'b01});
    if (rem2 >= trial) begin
      rem_next  = rem2 - trial;
      root_next = {root[hpw_pkg::SQRT_STEPS-2:0], 1'b1};
    end else begin
      rem_next  = rem2;
      root_next = {root[hpw_pkg::SQRT_STEPS-2:0], 1'b0};
    end
    head = root_neg ? -(32'(root_next)) : 32'(root_next);
  end

  always_comb begin
    wr_en   = word_ok || cmd.root_store;
    wr_addr = cmd.root_store ? 5'(hpw_pkg::HEAD_BASE) + 5'(cmd.comp) : load_index;
    wr_data = cmd.root_store ? head : load_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 12; i++) mat[i] <= '0;
    end else if (word_ok && load_index < 5'd12) begin
      mat[load_index[3:0]] <= load_value;
    end
  end

  // operand store: input words, then head components
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpw_pkg::MEM_DEPTH; i++) mem[i] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_rd) begin
      rda <= mem[op.a];
      rdb <= mem[op.b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad      <= rad_init;
      rem      <= '0;
      root     <= '0;
      root_neg <= diff[32];
    end else if (cmd.root_step) begin
      rad  <= {rad[hpw_pkg::RAD_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
    end
  end

  always_comb begin
    op   = hpw_pkg::step_op(cmd.step);
    term = prod[hpw_pkg::PROD_W-1:hpw_pkg::FRAC_BITS];
    unique case (op.dest)
      3'd0:    init = ACC_W'(mat[3]);
      3'd1:    init = ACC_W'(mat[7]);
      3'd2:    init = ACC_W'(mat[11]);
      default: init = '0;
    endcase
    base     = op.first ? init : acc;
    acc_next = op.neg ? base - ACC_W'(term) : base + ACC_W'(term);
    if (acc_next > SAT_MAX)
      sat_val = SAT_MAX[31:0];
    else if (acc_next < SAT_MIN)
      sat_val = SAT_MIN[31:0];
    else
      sat_val = acc_next[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_mul) prod <= rda * rdb;
    if (cmd.mul_acc) begin
      acc <= acc_next;
      if (op.last) res[op.dest] <= sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)
      res_valid <= 1'b0;
    else if (cmd.set_valid)
      res_valid <= 1'b1;
    else if (res_ready)
      res_valid <= 1'b0;
  end

  assign status.busy = res_valid && !res_ready;

endmodule

@@ rtl/hand_pose_to_world_transform_core.sv @@
// Top level of the hand pose to world transform block.
// Depends on hpw_pkg, hpw_if, hpw_ctrl and hpw_dp.
//
//   port      dir    content
//   words     sink   word_index, word_value (one Q16.16 word per request)
//   results   source world_x/y/z, rot_w/x/y/z (one per request at index 18)
//
// Words 0..17 are stored as they are taken; out-of-range indexes are dropped.
// Index 18 runs four 24-step roots on a one-bit-per-cycle root unit, then
// 25 products on one shared multiplier; no new words are taken meanwhile.
// Reset clears all stored words to zero and drops any pending result.
// A waiting result holds; new words are taken once it is being taken.
module hand_pose_to_world_transform_core (
  input logic clk,
  input logic rst,
  hpw_in_if.sink    words,
  hpw_out_if.source results
);

  hpw_pkg::cmd_t    cmd;
  hpw_pkg::status_t status;
  logic signed [31:0] res [7];

  hpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (words.valid),
    .req_index (words.word_index),
    .req_ready (words.ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .load       (words.valid && words.ready),
    .load_index (words.word_index),
    .load_value (words.word_value),
    .cmd        (cmd),
    .status     (status),
    .res_valid  (results.valid),
    .res_ready  (results.ready),
    .res        (res)
  );

  assign results.world_x = res[0];
  assign results.world_y = res[1];
  assign results.world_z = res[2];
  assign results.rot_w   = res[3];
  assign results.rot_x   = res[4];
  assign results.rot_y   = res[5];
  assign results.rot_z   = res[6];

endmodule
